FILE: src/keypad_scan_led_multiplexer_assert.svh
// Assertion macros shared by the keypad scanner modules.
`ifndef KEYPAD_SCAN_LED_MULTIPLEXER_ASSERT_SVH
`define KEYPAD_SCAN_LED_MULTIPLEXER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KSLM_ASSERT_SAME(name, clk, rstn, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
    else $error("keypad scanner check failed");

// Next-cycle implication, disabled while reset is asserted.
`define KSLM_ASSERT_NEXT(name, clk, rstn, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("keypad scanner check failed");

`endif

FILE: src/kpmux_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package kpmux_pkg;

  localparam int DEF_COLUMNS = 10;
  localparam int DEF_ROWS    = 8;

  localparam int ACTION_W    = 3;
  localparam int INDEX_W     = 7;
  localparam int SENSE_W     = 8;
  localparam int COL_DRIVE_W = 10;
  localparam int LED_DRIVE_W = 8;

  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK = 3'd0,
    ACT_READ = 3'd1,
    ACT_SET  = 3'd2,
    ACT_COPY = 3'd3,
    ACT_FILL = 3'd4
  } action_e;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  typedef struct packed {
    logic load;
    logic exec;
    logic tick;
    logic read;
    logic set_led;
    logic copy;
    logic fill;
  } cmd_t;

  typedef struct packed {
    action_e action;
  } status_t;

endpackage

`default_nettype wire

FILE: src/kpmux_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
`include "keypad_scan_led_multiplexer_assert.svh"

module kpmux_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire kpmux_pkg::status_t status_i,
  output kpmux_pkg::cmd_t         cmd_o
);
  import kpmux_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        busy_o     = 1'b1;
        cmd_o.exec = 1'b1;
        state_d    = ST_IDLE;
        unique case (status_i.action)
          ACT_TICK: cmd_o.tick    = 1'b1;
          ACT_READ: cmd_o.read    = 1'b1;
          ACT_SET:  cmd_o.set_led = 1'b1;
          ACT_COPY: cmd_o.copy    = 1'b1;
          ACT_FILL: cmd_o.fill    = 1'b1;
          default: begin
          end
        endcase
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  `KSLM_ASSERT_NEXT(a_accept_goes_busy, clk_i, rst_ni, start_i && !busy_o, busy_o)
  `KSLM_ASSERT_NEXT(a_single_exec_cycle, clk_i, rst_ni, busy_o, !busy_o)
  `KSLM_ASSERT_SAME(a_one_op, clk_i, rst_ni, 1'b1,
    $onehot0({cmd_o.tick, cmd_o.read, cmd_o.set_led, cmd_o.copy, cmd_o.fill}))

endmodule

`default_nettype wire

FILE: src/kpmux_dp.sv
`timescale 1ns / 1ps
`default_nettype none
`include "keypad_scan_led_multiplexer_assert.svh"

module kpmux_dp #(
  parameter int COLUMNS = kpmux_pkg::DEF_COLUMNS,
  parameter int ROWS    = kpmux_pkg::DEF_ROWS
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire kpmux_pkg::cmd_t                   cmd_i,
  output kpmux_pkg::status_t                     status_o,
  input  wire logic [kpmux_pkg::ACTION_W-1:0]    action_i,
  input  wire logic [kpmux_pkg::INDEX_W-1:0]     index_i,
  input  wire logic                              value_i,
  input  wire logic [kpmux_pkg::SENSE_W-1:0]     row_sense_i,
  output logic                                   done_o,
  output logic [kpmux_pkg::COL_DRIVE_W-1:0]      column_drive_o,
  output logic [kpmux_pkg::LED_DRIVE_W-1:0]      led_drive_o,
  output logic                                   button_state_o,
  output logic                                   changed_o
);
  import kpmux_pkg::*;

  localparam int KEY_COUNT = COLUMNS * ROWS;
  localparam int CW = $clog2(COLUMNS);
  localparam int KW = $clog2(KEY_COUNT);
  localparam int IW = (KW > INDEX_W) ? KW : INDEX_W;
  localparam int SW = (ROWS > SENSE_W) ? ROWS : SENSE_W;
  localparam int LW = (ROWS > LED_DRIVE_W) ? ROWS : LED_DRIVE_W;
  localparam int DW = (COLUMNS > COL_DRIVE_W) ? COLUMNS : COL_DRIVE_W;

  logic [ACTION_W-1:0] action_q;
  logic [INDEX_W-1:0]  index_q;
  logic                value_q;
  logic [SENSE_W-1:0]  sense_q;

  logic [CW-1:0]                 col_q, col_d;
  logic [COLUMNS-1:0][ROWS-1:0]  key_q, key_d;
  logic [COLUMNS-1:0][ROWS-1:0]  led_q, led_d;
  logic [KEY_COUNT-1:0]          last_q, last_d;

  logic                    done_q;
  logic [COL_DRIVE_W-1:0]  column_drive_q, column_drive_d;
  logic [LED_DRIVE_W-1:0]  led_drive_q, led_drive_d;
  logic                    button_q, button_d;
  logic                    changed_q, changed_d;

  logic [IW-1:0]        idx_ext;
  logic [KW-1:0]        key_idx;
  logic                 idx_ok;
  logic [KEY_COUNT-1:0] key_flat;
  logic [KEY_COUNT-1:0] led_flat;
  logic                 key_bit;
  logic [SENSE_W-1:0]   sense_n;
  logic [SW-1:0]        sense_ext;
  logic [LW-1:0]        led_row_ext;
  logic [DW-1:0]        col_onehot;

  assign status_o.action = action_e'(action_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      action_q <= action_i;
      index_q  <= index_i;
      value_q  <= value_i;
      sense_q  <= row_sense_i;
    end
  end

  assign idx_ext  = IW'(index_q);
  assign key_idx  = idx_ext[KW-1:0];
  assign idx_ok   = 32'(index_q) < 32'(KEY_COUNT);
  assign key_flat = key_q;
  assign key_bit  = key_flat[key_idx];
  assign sense_n   = ~sense_q;
  assign sense_ext = SW'(sense_n);

  always_comb begin
    col_d     = col_q;
    key_d     = key_q;
    led_flat  = led_q;
    last_d    = last_q;
    button_d  = 1'b0;
    changed_d = 1'b0;
    if (cmd_i.tick) begin
      key_d[col_q] = sense_ext[ROWS-1:0];
      col_d = (col_q == CW'(COLUMNS - 1)) ? '0 : col_q + 1'b1;
    end
    if (cmd_i.read && idx_ok) begin
      button_d        = key_bit;
      changed_d       = last_q[key_idx] ^ key_bit;
      last_d[key_idx] = key_bit;
    end
    if (cmd_i.set_led && idx_ok) begin
      led_flat[key_idx] = value_q;
    end
    if (cmd_i.copy) begin
      led_flat = key_q;
    end
    if (cmd_i.fill) begin
      led_flat = {KEY_COUNT{value_q}};
    end
    led_d = led_flat;
  end

  always_comb begin
    col_onehot     = DW'(1) << col_d;
    column_drive_d = col_onehot[COL_DRIVE_W-1:0];
    led_row_ext    = LW'(led_d[col_d]);
    led_drive_d    = led_row_ext[LED_DRIVE_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      key_q  <= '0;
      led_q  <= '0;
      last_q <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.exec;
      if (cmd_i.exec) begin
        col_q  <= col_d;
        key_q  <= key_d;
        led_q  <= led_d;
        last_q <= last_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      column_drive_q <= column_drive_d;
      led_drive_q    <= led_drive_d;
      button_q       <= button_d;
      changed_q      <= changed_d;
    end
  end

  assign done_o         = done_q;
  assign column_drive_o = column_drive_q;
  assign led_drive_o    = led_drive_q;
  assign button_state_o = button_q;
  assign changed_o      = changed_q;

  `KSLM_ASSERT_SAME(a_col_in_range, clk_i, rst_ni, 1'b1, col_q <= CW'(COLUMNS - 1))
  `KSLM_ASSERT_SAME(a_drive_onehot, clk_i, rst_ni, done_o, $onehot0(column_drive_o))
  `KSLM_ASSERT_NEXT(a_no_flag_outside_read, clk_i, rst_ni, cmd_i.exec && !cmd_i.read,
    !button_state_o && !changed_o)

endmodule

`default_nettype wire

FILE: src/keypad_scan_led_multiplexer.sv
`timescale 1ns / 1ps
`default_nettype none
// Keypad matrix scanner with LED multiplexing.
// Command channel: an action (scan tick, read button, set LED, copy keys to
// LEDs, set all LEDs) with index, value and row_sense is taken at a rising
// edge where start is high and busy is low.
// Result channel: done_o is high for exactly one cycle per command and marks
// column_drive_o, led_drive_o, button_state_o and changed_o for that cycle.
// The drive outputs show the active column and its LED row after the action;
// button_state_o and changed_o are nonzero only for a read of a valid button.
// Timing: the command executes in the cycle after it is taken, and done_o
// is high in the cycle after that.
// The controller has a single execute state and takes no new command while
// busy; start may be raised again in the cycle that done_o shows.
// Reset clears the active column, the key and LED images and the last-read
// flags; the first command may follow right after reset is released.
// The receiver cannot stall: done_o marks the results for their one cycle only.

module keypad_scan_led_multiplexer #(
  parameter int COLUMNS = kpmux_pkg::DEF_COLUMNS,
  parameter int ROWS    = kpmux_pkg::DEF_ROWS
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [kpmux_pkg::ACTION_W-1:0] action_i,
  input  wire logic [kpmux_pkg::INDEX_W-1:0]  index_i,
  input  wire logic                          value_i,
  input  wire logic [kpmux_pkg::SENSE_W-1:0]  row_sense_i,
  output logic                               done_o,
  output logic [kpmux_pkg::COL_DRIVE_W-1:0]  column_drive_o,
  output logic [kpmux_pkg::LED_DRIVE_W-1:0]  led_drive_o,
  output logic                               button_state_o,
  output logic                               changed_o
);
  import kpmux_pkg::*;

  cmd_t    cmd;
  status_t status;

  kpmux_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .busy_o   (busy),
    .status_i (status),
    .cmd_o    (cmd)
  );

  kpmux_dp #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .action_i       (action_i),
    .index_i        (index_i),
    .value_i        (value_i),
    .row_sense_i    (row_sense_i),
    .done_o         (done_o),
    .column_drive_o (column_drive_o),
    .led_drive_o    (led_drive_o),
    .button_state_o (button_state_o),
    .changed_o      (changed_o)
  );

endmodule

`default_nettype wire
